>>> rtl/cca_pkg.sv
// Package with the date type, command codes and calendar helper functions of the calendar clock.
package cca_pkg;

    typedef enum logic {
        CMD_ADVANCE = 1'b0,
        CMD_LOAD    = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [2:0]  weekday;
        logic [15:0] year;
    } date_t;

    localparam logic [3:0] MONTH_DEC   = 4'd11;
    localparam logic [2:0] WEEKDAY_SAT = 3'd6;

    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd1:    len = 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic date_t next_day(input date_t d);
        date_t      r;
        logic [5:0] day_inc;
        r = d;
        day_inc = {1'b0, d.day} + 6'd1;
        r.weekday = (d.weekday >= WEEKDAY_SAT) ? 3'd0 : d.weekday + 3'd1;
        if (day_inc > {1'b0, month_len(d.month)}) begin
            r.day = 5'd1;
            if (d.month >= MONTH_DEC) begin
                r.month = 4'd0;
                r.year  = d.year + 16'd1;
            end else begin
                r.month = d.month + 4'd1;
            end
        end else begin
            r.day = day_inc[4:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/calendar_clock_advance_core.sv
// Top level of the calendar clock: duration split stage and date update stage.
// The block holds a calendar date and time and returns it after every input transfer:
// an advance adds up to 65535 seconds with carries through minutes, hours, days,
// months (fixed lengths, February at 28 days) and the 16-bit year, and a load writes
// all fields as given. An item passes two registered stages: the input stage splits
// the duration into hours, minutes and seconds with two constant reciprocal multipliers,
// and the date stage adds that split to the held date and applies up to two day rollovers.
// A new item is taken every cycle while no result stalls; the result register holds
// the date and stalls only the input register behind it when the result is not taken.
// After reset the date is day 1 of January, year 0, at 00:00:00, weekday 0.
module calendar_clock_advance_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [15:0] s_duration,
    input  logic [5:0]  s_load_second,
    input  logic [5:0]  s_load_minute,
    input  logic [4:0]  s_load_hour,
    input  logic [4:0]  s_load_day,
    input  logic [3:0]  s_load_month,
    input  logic [2:0]  s_load_weekday,
    input  logic [15:0] s_load_year,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_cur_second,
    output logic [5:0]  m_cur_minute,
    output logic [4:0]  m_cur_hour,
    output logic [4:0]  m_cur_day,
    output logic [3:0]  m_cur_month,
    output logic [2:0]  m_cur_weekday,
    output logic [15:0] m_cur_year
);
    import cca_pkg::*;

    logic        in_valid_reg;
    logic        in_load_reg;
    logic [5:0]  in_dur_sec_reg;
    logic [5:0]  in_dur_min_reg;
    logic [4:0]  in_dur_hour_reg;
    date_t       in_load_date_reg;
    date_t       date_reg;
    date_t       date_next;
    logic        out_valid_reg;
    logic        advance;

    logic [29:0] q60_prod;
    logic [10:0] q60;
    logic [24:0] q3600_prod;
    logic [4:0]  q3600;
    logic [15:0] dur_sec_full;
    logic [10:0] dur_min_full;

    logic [6:0]  sec_sum;
    logic [1:0]  sec_carry;
    logic [6:0]  sec_wrap;
    logic [6:0]  min_sum;
    logic [1:0]  min_carry;
    logic [6:0]  min_wrap;
    logic [5:0]  hour_sum;
    logic [1:0]  day_carry;
    logic [5:0]  hour_wrap;
    date_t       adv_base;
    date_t       adv_one;
    date_t       adv_two;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // The duration is split into whole hours, minutes and seconds before it meets the date.
    assign q60_prod     = {16'd0, s_duration[15:2]} * 30'h8889;
    assign q60          = q60_prod[29:19];
    assign q3600_prod   = {13'd0, s_duration[15:4]} * 25'd4661;
    assign q3600        = q3600_prod[24:20];
    assign dur_sec_full = s_duration - {q60[9:0], 6'd0} + {3'd0, q60, 2'd0};
    assign dur_min_full = q60 - {q3600, 6'd0} + {4'd0, q3600, 2'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_load_reg              <= (s_command == CMD_LOAD);
            in_dur_sec_reg           <= dur_sec_full[5:0];
            in_dur_min_reg           <= dur_min_full[5:0];
            in_dur_hour_reg          <= q3600;
            in_load_date_reg.second  <= s_load_second;
            in_load_date_reg.minute  <= s_load_minute;
            in_load_date_reg.hour    <= s_load_hour;
            in_load_date_reg.day     <= s_load_day;
            in_load_date_reg.month   <= s_load_month;
            in_load_date_reg.weekday <= s_load_weekday;
            in_load_date_reg.year    <= s_load_year;
        end
    end

    always_comb begin
        sec_sum = {1'b0, date_reg.second} + {1'b0, in_dur_sec_reg};
        if (sec_sum >= 7'd120) begin
            sec_carry = 2'd2;
            sec_wrap  = sec_sum - 7'd120;
        end else if (sec_sum >= 7'd60) begin
            sec_carry = 2'd1;
            sec_wrap  = sec_sum - 7'd60;
        end else begin
            sec_carry = 2'd0;
            sec_wrap  = sec_sum;
        end

        min_sum = {1'b0, date_reg.minute} + {1'b0, in_dur_min_reg} + {5'd0, sec_carry};
        if (min_sum >= 7'd120) begin
            min_carry = 2'd2;
            min_wrap  = min_sum - 7'd120;
        end else if (min_sum >= 7'd60) begin
            min_carry = 2'd1;
            min_wrap  = min_sum - 7'd60;
        end else begin
            min_carry = 2'd0;
            min_wrap  = min_sum;
        end

        hour_sum = {1'b0, date_reg.hour} + {1'b0, in_dur_hour_reg} + {4'd0, min_carry};
        if (hour_sum >= 6'd48) begin
            day_carry = 2'd2;
            hour_wrap = hour_sum - 6'd48;
        end else if (hour_sum >= 6'd24) begin
            day_carry = 2'd1;
            hour_wrap = hour_sum - 6'd24;
        end else begin
            day_carry = 2'd0;
            hour_wrap = hour_sum;
        end

        adv_base        = date_reg;
        adv_base.second = sec_wrap[5:0];
        adv_base.minute = min_wrap[5:0];
        adv_base.hour   = hour_wrap[4:0];
        adv_one = (day_carry != 2'd0) ? next_day(adv_base) : adv_base;
        adv_two = (day_carry == 2'd2) ? next_day(adv_one) : adv_one;

        date_next = in_load_reg ? in_load_date_reg : adv_two;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            date_reg.second  <= 6'd0;
            date_reg.minute  <= 6'd0;
            date_reg.hour    <= 5'd0;
            date_reg.day     <= 5'd1;
            date_reg.month   <= 4'd0;
            date_reg.weekday <= 3'd0;
            date_reg.year    <= 16'd0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                date_reg      <= date_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_cur_second  = date_reg.second;
    assign m_cur_minute  = date_reg.minute;
    assign m_cur_hour    = date_reg.hour;
    assign m_cur_day     = date_reg.day;
    assign m_cur_month   = date_reg.month;
    assign m_cur_weekday = date_reg.weekday;
    assign m_cur_year    = date_reg.year;

endmodule

>>> rtl/cca_checker.sv
// Port-level checker of the calendar clock and its bind to the top level.
module cca_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_cur_second,
    input logic [5:0]  m_cur_minute,
    input logic [4:0]  m_cur_hour,
    input logic [4:0]  m_cur_day,
    input logic [3:0]  m_cur_month,
    input logic [2:0]  m_cur_weekday,
    input logic [15:0] m_cur_year
);

    // A result that is not taken stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped before its transfer");

    // A stalled result keeps its date.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_cur_second) && $stable(m_cur_minute)
            && $stable(m_cur_hour) && $stable(m_cur_day) && $stable(m_cur_month)
            && $stable(m_cur_weekday) && $stable(m_cur_year))
        else $error("stalled result changed");

    // The input side only stalls when a result is waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // Reset leaves no result pending and the start date on the outputs.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && m_cur_second == 6'd0 && m_cur_minute == 6'd0
            && m_cur_hour == 5'd0 && m_cur_day == 5'd1 && m_cur_month == 4'd0
            && m_cur_weekday == 3'd0 && m_cur_year == 16'd0)
        else $error("wrong state after reset");

endmodule

bind calendar_clock_advance_core cca_checker u_cca_checker (.*);
